/* rtl/core/expl_pkg.sv */
// ----------------------------------------------------------------------------
// Expression lexer package
// Shared widths, result kind codes and the types that travel between the
// front end, the result queue and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

package expl_pkg;

	localparam int CHAR_W     = 8;
	localparam int POS_W      = 10;
	localparam int LEN_W      = 11;
	localparam int IDX_W      = 9;
	localparam int KIND_W     = 4;
	localparam int LIMIT_W    = 9;
	localparam int TOKEN_CAP  = 256;
	localparam int MAX_LINE   = 1024;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(TOKEN_CAP);

	localparam logic [KIND_W-1:0] K_IDENT = 4'd0;
	localparam logic [KIND_W-1:0] K_INT   = 4'd1;
	localparam logic [KIND_W-1:0] K_REAL  = 4'd2;
	localparam logic [KIND_W-1:0] K_STR   = 4'd3;
	localparam logic [KIND_W-1:0] K_OP    = 4'd4;
	localparam logic [KIND_W-1:0] K_END   = 4'd5;
	localparam logic [KIND_W-1:0] K_BAD   = 4'd6;
	localparam logic [KIND_W-1:0] K_NOEXP = 4'd7;
	localparam logic [KIND_W-1:0] K_TICK  = 4'd8;
	localparam logic [KIND_W-1:0] K_LONG  = 4'd9;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [POS_W-1:0]  start_pos;
		logic [LEN_W-1:0]  tok_length;
		logic [IDX_W-1:0]  tok_index;
	} res_t;

	// One queue entry holds every result of one input item.
	typedef struct packed {
		res_t r0;
		res_t r1;
		logic two;
	} entry_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

endpackage

`default_nettype wire

/* rtl/core/expl_if.sv */
// ----------------------------------------------------------------------------
// Expression lexer channels
// Valid/ready channels for input characters and for lexer results.
// ----------------------------------------------------------------------------
`default_nettype none

interface expl_in_if;
	logic                        valid;
	logic                        ready;
	logic [expl_pkg::CHAR_W-1:0] ch;
	logic                        end_of_line;

	modport source (output valid, output ch, output end_of_line, input ready);
	modport sink (input valid, input ch, input end_of_line, output ready);
endinterface

interface expl_out_if;
	logic                        valid;
	logic                        ready;
	logic [expl_pkg::KIND_W-1:0] kind;
	logic [expl_pkg::POS_W-1:0]  start_pos;
	logic [expl_pkg::LEN_W-1:0]  tok_length;
	logic [expl_pkg::IDX_W-1:0]  tok_index;
	logic                        run_last;

	modport source (output valid, output kind, output start_pos, output tok_length,
		output tok_index, output run_last, input ready);
	modport sink (input valid, input kind, input start_pos, input tok_length,
		input tok_index, input run_last, output ready);
endinterface

`default_nettype wire

/* rtl/core/expl_front.sv */
// ----------------------------------------------------------------------------
// Expression lexer front end
// Accepts one character item per cycle while the result queue is not full, runs
// the tokenizer state machine and pushes the results of each item, if any, as one entry into the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module expl_front (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               cfg_we,
	input  wire [expl_pkg::LIMIT_W-1:0]       cfg_wdata,
	expl_in_if.sink                           in_ch,
	input  expl_pkg::q_stat_t                 qstat,
	output logic                              push,
	output expl_pkg::entry_t                  push_data
);

	typedef enum logic [8:0] {
		M_IDLE  = 9'b000000001,
		M_IDENT = 9'b000000010,
		M_INT   = 9'b000000100,
		M_FRAC  = 9'b000001000,
		M_EXPS  = 9'b000010000,
		M_EXPM  = 9'b000100000,
		M_EXPD  = 9'b001000000,
		M_STR   = 9'b010000000,
		M_OP    = 9'b100000000
	} mode_t;

	typedef struct packed {
		logic                          open;
		mode_t                         mode;
		logic [expl_pkg::LEN_W-1:0]    len;
		logic                          set_quote;
		logic                          set_pend;
		logic                          emit;
		logic [expl_pkg::KIND_W-1:0]   kind;
		logic                          inc;
		logic                          halt;
	} sc_t;

	localparam logic [expl_pkg::CHAR_W-1:0] CH_TICK = 8'h60;

	function automatic logic is_digit(input logic [expl_pkg::CHAR_W-1:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [expl_pkg::CHAR_W-1:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_space(input logic [expl_pkg::CHAR_W-1:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic sc_t start_char(input logic [expl_pkg::CHAR_W-1:0] c);
		sc_t s;
		s = '0;
		s.mode = M_IDLE;
		if (is_space(c)) begin
			s.open = 1'b0;
		end else if (c == CH_TICK) begin
			s.emit = 1'b1;
			s.kind = expl_pkg::K_TICK;
			s.halt = 1'b1;
		end else if (is_alpha(c)) begin
			s.open = 1'b1;
			s.mode = M_IDENT;
			s.len  = 11'd1;
		end else if (is_digit(c)) begin
			s.open = 1'b1;
			s.mode = M_INT;
			s.len  = 11'd1;
		end else if (c == ".") begin
			s.open = 1'b1;
			s.mode = M_FRAC;
			s.len  = 11'd1;
		end else if (c inside {"'", "\""}) begin
			s.open      = 1'b1;
			s.mode      = M_STR;
			s.len       = 11'd2;
			s.set_quote = 1'b1;
		end else if (c inside {"+", "-", "^", "/", "%", "~", "{", "}", "(", ")", "[", "]",
				";", ":", "?", ",", "#", "$"}) begin
			s.open = 1'b1;
			s.len  = 11'd1;
			s.emit = 1'b1;
			s.kind = expl_pkg::K_OP;
			s.inc  = 1'b1;
		end else if (c inside {"&", "|", "=", "*", "!", "<", ">"}) begin
			s.open     = 1'b1;
			s.mode     = M_OP;
			s.len      = 11'd1;
			s.set_pend = 1'b1;
		end else begin
			s.emit = 1'b1;
			s.kind = expl_pkg::K_BAD;
			s.halt = 1'b1;
		end
		return s;
	endfunction

	logic [expl_pkg::LIMIT_W-1:0] limit_q;
	mode_t                        mode_q, mode_n;
	logic [expl_pkg::POS_W:0]     pos_q, pos_n;
	logic [expl_pkg::POS_W-1:0]   ostart_q, ostart_n;
	logic [expl_pkg::LEN_W-1:0]   olen_q, olen_n;
	logic [expl_pkg::CHAR_W-1:0]  quote_q, quote_n;
	logic [expl_pkg::CHAR_W-1:0]  pend_q, pend_n;
	logic [expl_pkg::IDX_W-1:0]   cnt_q, cnt_n;
	logic                         halt_q, halt_n;

	logic [expl_pkg::LIMIT_W-1:0] lim;
	logic [expl_pkg::CHAR_W-1:0]  c;
	logic [expl_pkg::POS_W-1:0]   p;
	logic [expl_pkg::IDX_W-1:0]   cnt_inc;
	logic [expl_pkg::POS_W:0]     endpos;
	logic                         accept;
	logic                         a_v, b_v;
	expl_pkg::res_t               a, b;
	logic                         fin, do_start, pos_inc;
	logic [expl_pkg::KIND_W-1:0]  fin_kind;
	logic [expl_pkg::IDX_W-1:0]   sc_cnt;
	logic                         op_match;
	sc_t                          sc;

	assign lim = (limit_q > expl_pkg::LIMIT_W'(expl_pkg::TOKEN_CAP))
		? expl_pkg::LIMIT_W'(expl_pkg::TOKEN_CAP) : limit_q;
	assign c        = in_ch.ch;
	assign p        = pos_q[expl_pkg::POS_W-1:0];
	assign cnt_inc  = cnt_q + 9'd1;
	assign accept   = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !qstat.full;

	assign op_match = ((pend_q inside {"&", "|", "=", "*"}) && c == pend_q)
		|| ((pend_q inside {"!", "<", ">"}) && c == "=");

	always_comb begin
		mode_n   = mode_q;
		pos_n    = pos_q;
		ostart_n = ostart_q;
		olen_n   = olen_q;
		quote_n  = quote_q;
		pend_n   = pend_q;
		cnt_n    = cnt_q;
		halt_n   = halt_q;
		a_v      = 1'b0;
		b_v      = 1'b0;
		a        = '0;
		b        = '0;
		fin      = 1'b0;
		fin_kind = expl_pkg::K_IDENT;
		do_start = 1'b0;
		pos_inc  = 1'b1;
		sc_cnt   = cnt_q;
		endpos   = pos_q;
		sc       = start_char(c);

		if (in_ch.end_of_line) begin
			if (!halt_q) begin
				case (mode_q)
					M_IDENT: begin
						fin      = 1'b1;
						fin_kind = expl_pkg::K_IDENT;
					end
					M_INT: begin
						fin      = 1'b1;
						fin_kind = expl_pkg::K_INT;
					end
					M_FRAC, M_EXPD: begin
						fin      = 1'b1;
						fin_kind = expl_pkg::K_REAL;
					end
					M_EXPS, M_EXPM: begin
						a_v = 1'b1;
						a   = '{expl_pkg::K_NOEXP, p, '0, cnt_q};
					end
					M_STR: begin
						fin      = 1'b1;
						fin_kind = expl_pkg::K_STR;
						endpos   = pos_q + 11'd1;
					end
					M_OP: begin
						fin      = 1'b1;
						fin_kind = expl_pkg::K_OP;
					end
					default: begin
						fin = 1'b0;
					end
				endcase
			end
			sc_cnt = cnt_q;
			if (fin) begin
				a_v    = 1'b1;
				a      = '{fin_kind, ostart_q, olen_q, cnt_q};
				sc_cnt = cnt_inc;
			end
			b_v      = 1'b1;
			b        = '{expl_pkg::K_END, endpos[expl_pkg::POS_W-1:0], '0, sc_cnt};
			mode_n   = M_IDLE;
			pos_n    = '0;
			ostart_n = '0;
			olen_n   = '0;
			quote_n  = '0;
			pend_n   = '0;
			cnt_n    = '0;
			halt_n   = 1'b0;
		end else if (halt_q || cnt_q >= lim) begin
			pos_inc = 1'b0;
		end else if (pos_q >= (expl_pkg::POS_W+1)'(expl_pkg::MAX_LINE)) begin
			a_v     = 1'b1;
			a       = '{expl_pkg::K_LONG, expl_pkg::POS_W'(expl_pkg::MAX_LINE - 1), '0, cnt_q};
			halt_n  = 1'b1;
			mode_n  = M_IDLE;
			pos_inc = 1'b0;
		end else begin
			case (mode_q)
				M_IDENT: begin
					if (is_alpha(c) || is_digit(c) || c == "_") begin
						olen_n = olen_q + 11'd1;
					end else begin
						fin      = 1'b1;
						fin_kind = expl_pkg::K_IDENT;
					end
				end
				M_INT: begin
					if (is_digit(c)) begin
						olen_n = olen_q + 11'd1;
					end else if (c == ".") begin
						olen_n = olen_q + 11'd1;
						mode_n = M_FRAC;
					end else if (c inside {"e", "E"}) begin
						olen_n = olen_q + 11'd1;
						mode_n = M_EXPS;
					end else begin
						fin      = 1'b1;
						fin_kind = expl_pkg::K_INT;
					end
				end
				M_FRAC: begin
					if (is_digit(c)) begin
						olen_n = olen_q + 11'd1;
					end else if (c inside {"e", "E"}) begin
						olen_n = olen_q + 11'd1;
						mode_n = M_EXPS;
					end else begin
						fin      = 1'b1;
						fin_kind = expl_pkg::K_REAL;
					end
				end
				M_EXPS, M_EXPM: begin
					if (mode_q == M_EXPS && c == "-") begin
						olen_n = olen_q + 11'd1;
						mode_n = M_EXPM;
					end else if (is_digit(c)) begin
						olen_n = olen_q + 11'd1;
						mode_n = M_EXPD;
					end else begin
						a_v    = 1'b1;
						a      = '{expl_pkg::K_NOEXP, p, '0, cnt_q};
						halt_n = 1'b1;
						mode_n = M_IDLE;
					end
				end
				M_EXPD: begin
					if (is_digit(c)) begin
						olen_n = olen_q + 11'd1;
					end else begin
						fin      = 1'b1;
						fin_kind = expl_pkg::K_REAL;
					end
				end
				M_STR: begin
					if (c == quote_q) begin
						a_v    = 1'b1;
						a      = '{expl_pkg::K_STR, ostart_q, olen_q, cnt_q};
						cnt_n  = cnt_inc;
						mode_n = M_IDLE;
					end else begin
						olen_n = olen_q + 11'd1;
					end
				end
				M_OP: begin
					if (op_match) begin
						a_v    = 1'b1;
						a      = '{expl_pkg::K_OP, ostart_q, 11'd2, cnt_q};
						olen_n = 11'd2;
						cnt_n  = cnt_inc;
						mode_n = M_IDLE;
					end else begin
						fin      = 1'b1;
						fin_kind = expl_pkg::K_OP;
					end
				end
				default: begin
					do_start = 1'b1;
				end
			endcase

			if (fin) begin
				a_v    = 1'b1;
				a      = '{fin_kind, ostart_q, olen_q, cnt_q};
				cnt_n  = cnt_inc;
				mode_n = M_IDLE;
				sc_cnt = cnt_inc;
				if (cnt_inc >= lim) begin
					pos_inc = 1'b0;
				end else begin
					do_start = 1'b1;
				end
			end

			if (do_start) begin
				mode_n = sc.mode;
				cnt_n  = sc_cnt + {8'd0, sc.inc};
				if (sc.open) begin
					ostart_n = p;
					olen_n   = sc.len;
				end
				if (sc.set_quote) begin
					quote_n = c;
				end
				if (sc.set_pend) begin
					pend_n = c;
				end
				if (sc.halt) begin
					halt_n = 1'b1;
				end
				if (sc.emit) begin
					b_v = 1'b1;
					b   = '{sc.kind, p, sc.inc ? sc.len : 11'd0, sc_cnt};
				end
			end

			if (pos_inc) begin
				pos_n = pos_q + 11'd1;
			end
		end
	end

	always_comb begin
		push_data = '0;
		if (a_v) begin
			push_data.r0  = a;
			push_data.r1  = b;
			push_data.two = b_v;
		end else begin
			push_data.r0 = b;
		end
	end

	assign push = accept && (a_v || b_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= expl_pkg::LIMIT_RESET;
			mode_q   <= M_IDLE;
			pos_q    <= '0;
			ostart_q <= '0;
			olen_q   <= '0;
			quote_q  <= '0;
			pend_q   <= '0;
			cnt_q    <= '0;
			halt_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (accept) begin
				mode_q   <= mode_n;
				pos_q    <= pos_n;
				ostart_q <= ostart_n;
				olen_q   <= olen_n;
				quote_q  <= quote_n;
				pend_q   <= pend_n;
				cnt_q    <= cnt_n;
				halt_q   <= halt_n;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/expl_queue.sv */
// ----------------------------------------------------------------------------
// Expression lexer result queue
// Short FIFO of per-item result entries between the front end and the
// output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module expl_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  expl_pkg::entry_t     push_data,
	input  wire                  pop,
	output expl_pkg::entry_t     head,
	output expl_pkg::q_stat_t    qstat
);

	expl_pkg::entry_t              mem_q [expl_pkg::QUEUE_DEPTH];
	logic [expl_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [expl_pkg::QUEUE_CW-1:0] count_q;
	logic                          do_push, do_pop;

	assign qstat.full      = count_q == expl_pkg::QUEUE_CW'(expl_pkg::QUEUE_DEPTH);
	assign qstat.not_empty = count_q != '0;
	assign head            = mem_q[rd_ptr_q];
	assign do_push         = push && !qstat.full;
	assign do_pop          = pop && qstat.not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == expl_pkg::QUEUE_AW'(expl_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == expl_pkg::QUEUE_AW'(expl_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/expl_back.sv */
// ----------------------------------------------------------------------------
// Expression lexer output stage
// Hands out the results of the head queue entry one result at a time and
// marks the last result of each input item.
// ----------------------------------------------------------------------------
`default_nettype none

module expl_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  expl_pkg::entry_t     head,
	input  expl_pkg::q_stat_t    qstat,
	output logic                 pop,
	expl_out_if.source           res_ch
);

	logic           second_q;
	logic           last;
	logic           accept;
	expl_pkg::res_t cur;

	assign cur    = second_q ? head.r1 : head.r0;
	assign last   = second_q || !head.two;
	assign accept = res_ch.valid && res_ch.ready;
	assign pop    = accept && last;

	assign res_ch.valid      = qstat.not_empty;
	assign res_ch.kind       = cur.kind;
	assign res_ch.start_pos  = cur.start_pos;
	assign res_ch.tok_length = cur.tok_length;
	assign res_ch.tok_index  = cur.tok_index;
	assign res_ch.run_last   = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
		end else if (accept) begin
			second_q <= !last;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/expression_lexer.sv */
// ----------------------------------------------------------------------------
// Expression lexer
// Cuts a character stream into identifier, number, string and operator
// tokens with their kind, start position, length and index.
// ----------------------------------------------------------------------------
// The lexer takes one character item per clock cycle; each item yields zero,
// one or two results, and the end-of-line item always yields the end token.
// The front end settles an item in the cycle it is accepted and writes its
// results as one entry into a four-entry queue; the output stage sends one
// result per cycle while the output channel is ready, and input is held back
// only when the queue is full. Results reach the output channel only after
// their entry is registered in the queue.
`default_nettype none

module expression_lexer (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [expl_pkg::LIMIT_W-1:0]   cfg_wdata,
	expl_in_if.sink                       in_ch,
	expl_out_if.source                    res_ch
);

	expl_pkg::q_stat_t qstat;
	expl_pkg::entry_t  push_data;
	expl_pkg::entry_t  head;
	logic              push;
	logic              pop;

	expl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	expl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	expl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.res_ch (res_ch)
	);

endmodule

`default_nettype wire
